### src/assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define OSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define OSC_ASSERT_NEVER(name, cond, msg) \
  `OSC_ASSERT(name, !(cond), msg)

`endif

### src/osc_dec_pkg.sv
package osc_dec_pkg;

  // tag memory depth and string offset width
  localparam int MaxTags    = 32;
  localparam int OffsetBits = 16;

  localparam int TagCntW  = $clog2(MaxTags + 1);
  localparam int TagAddrW = (MaxTags > 1) ? $clog2(MaxTags) : 1;

  // result queue depth, power of two, at least two
  localparam int OfifoDepth = 4;

  // result kinds
  localparam logic [2:0] KindAddr   = 3'd0;
  localparam logic [2:0] KindTag    = 3'd1;
  localparam logic [2:0] KindInt    = 3'd2;
  localparam logic [2:0] KindFloat  = 3'd3;
  localparam logic [2:0] KindString = 3'd4;
  localparam logic [2:0] KindBlob   = 3'd5;
  localparam logic [2:0] KindEnd    = 3'd6;

  // end status codes
  localparam logic [2:0] StOk           = 3'd0;
  localparam logic [2:0] StMissingComma = 3'd1;
  localparam logic [2:0] StTruncated    = 3'd2;
  localparam logic [2:0] StTooManyTags  = 3'd3;
  localparam logic [2:0] StUnsupported  = 3'd4;

  // stored tag codes
  localparam logic [1:0] TagInt   = 2'd0;
  localparam logic [1:0] TagFloat = 2'd1;
  localparam logic [1:0] TagStr   = 2'd2;
  localparam logic [1:0] TagBlob  = 2'd3;

  // message characters
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharI     = 8'h69;
  localparam logic [7:0] CharF     = 8'h66;
  localparam logic [7:0] CharS     = 8'h73;
  localparam logic [7:0] CharB     = 8'h62;
  localparam logic [7:0] CharNul   = 8'h00;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       end_of_message;
  } osc_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [4:0]  arg_number;
    logic [2:0]  status;
    logic        is_last;
  } osc_out_t;

  // results produced by one request: a regular one and the end marker
  typedef struct packed {
    logic first_vld;
    logic end_vld;
  } push_t;

endpackage

### src/osc_dec_parser.sv
`include "assert_macros.svh"

module osc_dec_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  osc_dec_pkg::osc_in_t  in_data_i,
  output osc_dec_pkg::push_t    push_o,
  output osc_dec_pkg::osc_out_t res_a_o,
  output osc_dec_pkg::osc_out_t res_b_o
);

  typedef enum logic [2:0] {
    PhAddr,
    PhAddrPad,
    PhComma,
    PhTags,
    PhTagPad,
    PhArgs,
    PhString,
    PhBlob
  } phase_e;

  phase_e                                 phase_q, phase_d;
  logic [osc_dec_pkg::OffsetBits-1:0]     offset_q, offset_d;
  logic [osc_dec_pkg::TagCntW-1:0]        tag_count_q, tag_count_d;
  logic [osc_dec_pkg::TagCntW-1:0]        tag_cursor_q, tag_cursor_d;
  logic [1:0]                             wbi_q, wbi_d;
  logic [31:0]                            word_q, word_d;
  logic [31:0]                            blob_rem_q, blob_rem_d;
  logic [31:0]                            dcount_q, dcount_d;
  logic [2:0]                             err_q, err_d;

  logic [1:0]                             tag_mem_q [osc_dec_pkg::MaxTags];
  logic [1:0]                             tag_rd_q;
  logic                                   mem_we;
  logic [1:0]                             tag_code;
  logic                                   tag_known;

  logic [7:0]                             byte_v;
  logic [osc_dec_pkg::OffsetBits-1:0]     new_off;
  logic                                   aligned;
  logic [31:0]                            word_full;
  logic [2:0]                             final_st;

  assign byte_v    = in_data_i.msg_byte;
  assign new_off   = offset_q + osc_dec_pkg::OffsetBits'(1);
  assign aligned   = (new_off[1:0] == 2'b00);
  assign word_full = {word_q[23:0], byte_v};

  always_comb begin
    tag_code  = osc_dec_pkg::TagInt;
    tag_known = 1'b1;
    unique case (byte_v)
      osc_dec_pkg::CharI: tag_code = osc_dec_pkg::TagInt;
      osc_dec_pkg::CharF: tag_code = osc_dec_pkg::TagFloat;
      osc_dec_pkg::CharS: tag_code = osc_dec_pkg::TagStr;
      osc_dec_pkg::CharB: tag_code = osc_dec_pkg::TagBlob;
      default:            tag_known = 1'b0;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    offset_d     = offset_q;
    tag_count_d  = tag_count_q;
    tag_cursor_d = tag_cursor_q;
    wbi_d        = wbi_q;
    word_d       = word_q;
    blob_rem_d   = blob_rem_q;
    dcount_d     = dcount_q;
    err_d        = err_q;
    mem_we       = 1'b0;
    push_o       = '0;
    res_a_o      = '0;
    res_b_o      = '0;
    final_st     = osc_dec_pkg::StOk;

    if (fire_i) begin
      unique case (phase_q)
        PhAddr: begin
          if (byte_v != osc_dec_pkg::CharNul) begin
            push_o.first_vld = 1'b1;
            res_a_o.kind     = osc_dec_pkg::KindAddr;
            res_a_o.value    = 32'(byte_v);
          end else begin
            phase_d = aligned ? PhComma : PhAddrPad;
          end
        end
        PhAddrPad: begin
          if (aligned) phase_d = PhComma;
        end
        PhComma: begin
          if (byte_v == osc_dec_pkg::CharComma) begin
            phase_d = PhTags;
          end else begin
            if (err_q == osc_dec_pkg::StOk) err_d = osc_dec_pkg::StMissingComma;
            tag_count_d  = '0;
            tag_cursor_d = '0;
            phase_d      = PhArgs;
          end
        end
        PhTags: begin
          if (byte_v == osc_dec_pkg::CharNul) begin
            tag_cursor_d = '0;
            wbi_d        = '0;
            word_d       = '0;
            phase_d      = aligned ? PhArgs : PhTagPad;
          end else if (!tag_known) begin
            if (err_q == osc_dec_pkg::StOk) err_d = osc_dec_pkg::StUnsupported;
          end else if (tag_count_q < osc_dec_pkg::TagCntW'(osc_dec_pkg::MaxTags)) begin
            mem_we             = 1'b1;
            push_o.first_vld   = 1'b1;
            res_a_o.kind       = osc_dec_pkg::KindTag;
            res_a_o.value      = 32'(byte_v);
            res_a_o.arg_number = 5'(tag_count_q);
            tag_count_d        = tag_count_q + osc_dec_pkg::TagCntW'(1);
          end else begin
            if (err_q == osc_dec_pkg::StOk) err_d = osc_dec_pkg::StTooManyTags;
          end
        end
        PhTagPad: begin
          if (aligned) phase_d = PhArgs;
        end
        PhArgs: begin
          // tag_rd_q holds the entry at tag_cursor_q, registered from the cursor's next value
          if (tag_cursor_q < tag_count_q) begin
            if (tag_rd_q == osc_dec_pkg::TagStr) begin
              push_o.first_vld   = 1'b1;
              res_a_o.kind       = osc_dec_pkg::KindString;
              res_a_o.value      = 32'(offset_q);
              res_a_o.arg_number = 5'(tag_cursor_q);
              dcount_d           = dcount_q + 32'd4;
              blob_rem_d         = (byte_v == osc_dec_pkg::CharNul) ? 32'd1 : 32'd0;
              if (byte_v == osc_dec_pkg::CharNul && aligned) begin
                tag_cursor_d = tag_cursor_q + osc_dec_pkg::TagCntW'(1);
                blob_rem_d   = '0;
                word_d       = '0;
                wbi_d        = '0;
                phase_d      = PhArgs;
              end else begin
                phase_d = PhString;
              end
            end else begin
              word_d = word_full;
              if (wbi_q == 2'd3) begin
                word_d = '0;
                wbi_d  = '0;
                if (tag_rd_q == osc_dec_pkg::TagBlob) begin
                  if (word_full == 32'd0) begin
                    tag_cursor_d = tag_cursor_q + osc_dec_pkg::TagCntW'(1);
                    blob_rem_d   = '0;
                    phase_d      = PhArgs;
                  end else begin
                    blob_rem_d = word_full;
                    phase_d    = PhBlob;
                  end
                end else begin
                  push_o.first_vld   = 1'b1;
                  res_a_o.kind       = (tag_rd_q == osc_dec_pkg::TagInt) ?
                                       osc_dec_pkg::KindInt : osc_dec_pkg::KindFloat;
                  res_a_o.value      = word_full;
                  res_a_o.arg_number = 5'(tag_cursor_q);
                  dcount_d           = dcount_q + 32'd4;
                  tag_cursor_d       = tag_cursor_q + osc_dec_pkg::TagCntW'(1);
                  blob_rem_d         = '0;
                  phase_d            = PhArgs;
                end
              end else begin
                wbi_d = wbi_q + 2'd1;
              end
            end
          end
        end
        PhString: begin
          // blob_rem_q doubles as the string's nul-seen flag
          if ((byte_v == osc_dec_pkg::CharNul || blob_rem_q != 32'd0) && aligned) begin
            tag_cursor_d = tag_cursor_q + osc_dec_pkg::TagCntW'(1);
            blob_rem_d   = '0;
            word_d       = '0;
            wbi_d        = '0;
            phase_d      = PhArgs;
          end else if (byte_v == osc_dec_pkg::CharNul) begin
            blob_rem_d = 32'd1;
          end
        end
        PhBlob: begin
          if (blob_rem_q != 32'd0) begin
            push_o.first_vld   = 1'b1;
            res_a_o.kind       = osc_dec_pkg::KindBlob;
            res_a_o.value      = 32'(byte_v);
            res_a_o.arg_number = 5'(tag_cursor_q);
            dcount_d           = dcount_q + 32'd1;
            blob_rem_d         = blob_rem_q - 32'd1;
            if (blob_rem_q == 32'd1 && aligned) begin
              tag_cursor_d = tag_cursor_q + osc_dec_pkg::TagCntW'(1);
              blob_rem_d   = '0;
              word_d       = '0;
              wbi_d        = '0;
              phase_d      = PhArgs;
            end
          end else if (aligned) begin
            tag_cursor_d = tag_cursor_q + osc_dec_pkg::TagCntW'(1);
            blob_rem_d   = '0;
            word_d       = '0;
            wbi_d        = '0;
            phase_d      = PhArgs;
          end
        end
      endcase

      offset_d = new_off;

      if (in_data_i.end_of_message) begin
        final_st = err_d;
        if (final_st == osc_dec_pkg::StOk &&
            !(phase_d == PhArgs && tag_cursor_d >= tag_count_d && wbi_d == 2'd0)) begin
          final_st = osc_dec_pkg::StTruncated;
        end
        push_o.end_vld     = 1'b1;
        res_b_o.kind       = osc_dec_pkg::KindEnd;
        res_b_o.value      = dcount_d;
        res_b_o.arg_number = 5'(tag_cursor_d);
        res_b_o.status     = final_st;
        res_b_o.is_last    = 1'b1;

        // back to the start of a new message
        phase_d      = PhAddr;
        offset_d     = '0;
        tag_count_d  = '0;
        tag_cursor_d = '0;
        wbi_d        = '0;
        word_d       = '0;
        blob_rem_d   = '0;
        dcount_d     = '0;
        err_d        = osc_dec_pkg::StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhAddr;
      offset_q     <= '0;
      tag_count_q  <= '0;
      tag_cursor_q <= '0;
      wbi_q        <= '0;
      word_q       <= '0;
      blob_rem_q   <= '0;
      dcount_q     <= '0;
      err_q        <= osc_dec_pkg::StOk;
    end else begin
      phase_q      <= phase_d;
      offset_q     <= offset_d;
      tag_count_q  <= tag_count_d;
      tag_cursor_q <= tag_cursor_d;
      wbi_q        <= wbi_d;
      word_q       <= word_d;
      blob_rem_q   <= blob_rem_d;
      dcount_q     <= dcount_d;
      err_q        <= err_d;
    end
  end

  // tag memory: written during the tag list, read ahead at the next cursor.
  // a write and a read of the same entry only meet while still in the tag
  // list, and the entry is read again before any argument needs it
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem_q[tag_count_q[osc_dec_pkg::TagAddrW-1:0]] <= tag_code;
    end
    tag_rd_q <= tag_mem_q[tag_cursor_d[osc_dec_pkg::TagAddrW-1:0]];
  end

  `OSC_ASSERT(a_cursor_le_count, tag_cursor_q <= tag_count_q,
              "tag cursor ran past the stored tags")
  `OSC_ASSERT(a_count_bound, tag_count_q <= osc_dec_pkg::TagCntW'(osc_dec_pkg::MaxTags),
              "tag count above memory depth")
  `OSC_ASSERT(a_end_clears, fire_i && in_data_i.end_of_message |=>
              phase_q == PhAddr && tag_count_q == '0 && dcount_q == 32'd0,
              "state not cleared after end of message")
  `OSC_ASSERT_NEVER(a_write_outside_tags, mem_we && phase_q != PhTags,
                    "tag memory written outside the tag list")

endmodule

### src/osc_dec_ofifo.sv
`include "assert_macros.svh"

module osc_dec_ofifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  osc_dec_pkg::push_t    push_i,
  input  osc_dec_pkg::osc_out_t res_a_i,
  input  osc_dec_pkg::osc_out_t res_b_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output osc_dec_pkg::osc_out_t out_data_o
);

  localparam int PtrW = $clog2(osc_dec_pkg::OfifoDepth);
  localparam int CntW = $clog2(osc_dec_pkg::OfifoDepth + 1);

  osc_dec_pkg::osc_out_t buf_q [osc_dec_pkg::OfifoDepth];
  logic [PtrW-1:0]       wr_q, wr_d;
  logic [PtrW-1:0]       rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       npush;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // two free slots cover the worst request: a result plus the end marker
  assign room_o      = (cnt_q <= CntW'(osc_dec_pkg::OfifoDepth - 2));
  assign npush       = CntW'(push_i.first_vld) + CntW'(push_i.end_vld);

  always_comb begin
    wr_d  = wr_q + PtrW'(npush);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + npush - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) begin
      buf_q[wr_q] <= res_a_i;
    end
    if (push_i.end_vld) begin
      buf_q[push_i.first_vld ? wr_q + PtrW'(1) : wr_q] <= res_b_i;
    end
  end

  `OSC_ASSERT(a_cnt_bound, cnt_q <= CntW'(osc_dec_pkg::OfifoDepth),
              "result queue overfilled")
  `OSC_ASSERT(a_push_needs_room, push_i.first_vld || push_i.end_vld |-> room_o,
              "result pushed without two free slots")
  `OSC_ASSERT(a_pop_only, pop && !push_i.first_vld && !push_i.end_vld |=>
              cnt_q == $past(cnt_q) - CntW'(1),
              "queue level wrong after a lone pop")

endmodule

### src/osc_message_decoder.sv
// Byte-serial Open Sound Control 1.0 message parser. One message byte is
// taken per request, and with the result queue draining it takes a new byte
// every clock cycle. Each byte yields at most one result plus, on the byte
// marked end of message, the end result with the data byte count and the
// status; results are registered, never passed straight to the output.
// Results pass through a four-entry queue, and the input stalls whenever
// fewer than two slots are free, so a long output stall backs up into the
// input after a few bytes. Type tags live in a 32 x 2 bit memory, read
// ahead at the next cursor value for the argument that needs them; no
// clearing pass is needed after reset.
module osc_message_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  osc_dec_pkg::osc_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output osc_dec_pkg::osc_out_t out_data_o
);

  osc_dec_pkg::push_t    push;
  osc_dec_pkg::osc_out_t res_a;
  osc_dec_pkg::osc_out_t res_b;
  logic                  room;
  logic                  fire;

  assign in_stall_o = !room;
  assign fire       = in_valid_i && room;

  osc_dec_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_data_i (in_data_i),
    .push_o    (push),
    .res_a_o   (res_a),
    .res_b_o   (res_b)
  );

  osc_dec_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### bench/osc_decode_checker.sv
module osc_decode_checker
  import osc_dec_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  osc_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  osc_out_t out_data_i,
  output int       mismatch_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PhAddr, PhAddrPad, PhComma, PhTags, PhTagPad, PhArgs, PhString, PhBlob
  } parse_phase_e;

  osc_out_t awaited_results[$];

  parse_phase_e           phase;
  logic [OffsetBits-1:0]  byte_offset;
  logic [1:0]             tag_mem [MaxTags];
  int                     tag_count;
  int                     tag_cursor;
  logic [1:0]             word_index;
  logic [31:0]            word_acc;
  // blob bytes still due; for a string it flags that the NUL was seen
  logic [31:0]            arg_bytes_left;
  logic [31:0]            data_count;
  logic [2:0]             parse_error;

  function automatic void reset_parser();
    phase          = PhAddr;
    byte_offset    = '0;
    tag_count      = 0;
    tag_cursor     = 0;
    word_index     = '0;
    word_acc       = '0;
    arg_bytes_left = '0;
    data_count     = '0;
    parse_error    = StOk;
    for (int i = 0; i < MaxTags; i++) begin
      tag_mem[i] = TagInt;
    end
  endfunction

  function automatic void push_result(input logic [2:0] res_kind, input logic [31:0] res_value,
                                      input int res_arg, input logic [2:0] res_status,
                                      input logic res_last);
    awaited_results.push_back('{kind: res_kind, value: res_value, arg_number: 5'(res_arg),
                                status: res_status, is_last: res_last});
  endfunction

  function automatic void note_error(input logic [2:0] code);
    if (parse_error == StOk) begin
      parse_error = code;
    end
  endfunction

  function automatic void advance_arg();
    tag_cursor++;
    arg_bytes_left = '0;
    word_acc       = '0;
    word_index     = '0;
    phase          = PhArgs;
  endfunction

  function automatic void decode_byte(input osc_in_t req);
    logic [7:0]            b;
    logic [OffsetBits-1:0] off;
    logic [OffsetBits-1:0] next_off;
    logic                  aligned;
    logic [1:0]            tag;
    logic [31:0]           word;
    logic [2:0]            end_status;
    b        = req.msg_byte;
    off      = byte_offset;
    next_off = off + 1'b1;
    aligned  = (next_off[1:0] == 2'd0);
    case (phase)
      PhAddr: begin
        if (b != CharNul) begin
          push_result(KindAddr, 32'(b), 0, StOk, 1'b0);
        end else begin
          phase = aligned ? PhComma : PhAddrPad;
        end
      end
      PhAddrPad: begin
        if (aligned) phase = PhComma;
      end
      PhComma: begin
        if (b == CharComma) begin
          phase = PhTags;
        end else begin
          note_error(StMissingComma);
          tag_count  = 0;
          tag_cursor = 0;
          phase      = PhArgs;
        end
      end
      PhTags: begin
        if (b == CharNul) begin
          tag_cursor = 0;
          word_index = '0;
          word_acc   = '0;
          phase      = aligned ? PhArgs : PhTagPad;
        end else if (!(b inside {CharI, CharF, CharS, CharB})) begin
          note_error(StUnsupported);
        end else if (tag_count < MaxTags) begin
          tag_mem[tag_count] = (b == CharI) ? TagInt :
                               (b == CharF) ? TagFloat :
                               (b == CharS) ? TagStr : TagBlob;
          push_result(KindTag, 32'(b), tag_count, StOk, 1'b0);
          tag_count++;
        end else begin
          note_error(StTooManyTags);
        end
      end
      PhTagPad: begin
        if (aligned) phase = PhArgs;
      end
      PhArgs: begin
        if (tag_cursor < tag_count && tag_cursor < MaxTags) begin
          tag = tag_mem[tag_cursor];
          if (tag == TagStr) begin
            push_result(KindString, 32'(off), tag_cursor, StOk, 1'b0);
            data_count += 32'd4;
            arg_bytes_left = (b == CharNul) ? 32'd1 : 32'd0;
            if (b == CharNul && aligned) advance_arg();
            else phase = PhString;
          end else begin
            word_acc = {word_acc[23:0], b};
            if (word_index == 2'd3) begin
              word       = word_acc;
              word_acc   = '0;
              word_index = '0;
              if (tag == TagBlob) begin
                if (word == '0) begin
                  advance_arg();
                end else begin
                  arg_bytes_left = word;
                  phase          = PhBlob;
                end
              end else begin
                push_result((tag == TagInt) ? KindInt : KindFloat, word, tag_cursor, StOk,
                            1'b0);
                data_count += 32'd4;
                advance_arg();
              end
            end else begin
              word_index = word_index + 2'd1;
            end
          end
        end
      end
      PhString: begin
        if (b == CharNul) arg_bytes_left = 32'd1;
        if (arg_bytes_left != '0 && aligned) advance_arg();
      end
      PhBlob: begin
        if (arg_bytes_left != '0) begin
          push_result(KindBlob, 32'(b), tag_cursor, StOk, 1'b0);
          data_count += 32'd1;
          arg_bytes_left -= 32'd1;
          if (arg_bytes_left == '0 && aligned) advance_arg();
        end else if (aligned) begin
          advance_arg();
        end
      end
      default: ;
    endcase
    byte_offset = next_off;

    if (req.end_of_message) begin
      end_status = parse_error;
      if (end_status == StOk &&
          !(phase == PhArgs && tag_cursor >= tag_count && word_index == 2'd0)) begin
        end_status = StTruncated;
      end
      push_result(KindEnd, data_count, tag_cursor, end_status, 1'b1);
      reset_parser();
    end
  endfunction

  function automatic void check_result(input osc_out_t got);
    osc_out_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: kind %0d value %0h", got.kind, got.value);
      mismatch_count_o++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatch_count_o++;
    end
    if (got.value !== want.value) begin
      $error("value: expected %0h, got %0h", want.value, got.value);
      mismatch_count_o++;
    end
    if (got.arg_number !== want.arg_number) begin
      $error("arg_number: expected %0d, got %0d", want.arg_number, got.arg_number);
      mismatch_count_o++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatch_count_o++;
    end
    if (got.is_last !== want.is_last) begin
      $error("is_last: expected %0b, got %0b", want.is_last, got.is_last);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_parser();
      awaited_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
    end
    pending_o = awaited_results.size();
  end

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import osc_dec_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 500;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  osc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  osc_out_t out_data;
  int       mismatches;
  int       pending;
  int       cycle_count;
  int       random_bytes_sent;
  bit       sender_steady;
  logic [7:0] msg_q[$];

  osc_message_decoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  osc_decode_checker result_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic void add_padding();
    while (msg_q.size() % 4 != 0) msg_q.push_back(CharNul);
  endfunction

  function automatic void add_word(input logic [31:0] w);
    msg_q.push_back(w[31:24]);
    msg_q.push_back(w[23:16]);
    msg_q.push_back(w[15:8]);
    msg_q.push_back(w[7:0]);
  endfunction

  function automatic void add_address(input int len);
    repeat (len) msg_q.push_back(8'($urandom_range(1, 255)));
    msg_q.push_back(CharNul);
    add_padding();
  endfunction

  function automatic void add_tags(input string tags);
    for (int i = 0; i < tags.len(); i++) msg_q.push_back(tags[i]);
    msg_q.push_back(CharNul);
    add_padding();
  endfunction

  // argument data for the supported tags that the block keeps
  function automatic void add_args(input string tags);
    int kept;
    int len;
    kept = 0;
    for (int i = 0; i < tags.len(); i++) begin
      if (kept < MaxTags && tags[i] inside {CharI, CharF, CharS, CharB}) begin
        kept++;
        if (tags[i] == CharS) begin
          len = $urandom_range(0, 9);
          repeat (len) msg_q.push_back(8'($urandom_range(1, 255)));
          msg_q.push_back(CharNul);
          add_padding();
        end else if (tags[i] == CharB) begin
          len = $urandom_range(0, 9);
          add_word(32'(len));
          repeat (len) msg_q.push_back(8'($urandom));
          add_padding();
        end else begin
          add_word($urandom);
        end
      end
    end
  endfunction

  function automatic void build_random_message();
    int         shape;
    int         ntags;
    int         keep;
    logic [7:0] tc;
    string      tags;
    msg_q.delete();
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      repeat ($urandom_range(1, 16)) msg_q.push_back(8'($urandom));
      return;
    end
    add_address($urandom_range(0, 10));
    if (shape == 1) begin
      do tc = 8'($urandom); while (tc == CharComma);
      msg_q.push_back(tc);
    end else begin
      msg_q.push_back(CharComma);
    end
    ntags = (shape == 2) ? $urandom_range(30, 36) : $urandom_range(0, 5);
    tags = "";
    for (int t = 0; t < ntags; t++) begin
      if (shape == 3 && $urandom_range(0, 2) == 0) begin
        do tc = 8'($urandom_range(1, 255)); while (tc inside {CharI, CharF, CharS, CharB});
      end else begin
        case ($urandom_range(0, 3))
          0: tc = CharI;
          1: tc = CharF;
          2: tc = CharS;
          default: tc = CharB;
        endcase
      end
      tags = {tags, " "};
      tags.putc(t, tc);
    end
    add_tags(tags);
    add_args(tags);
    if (shape == 4 || shape == 5) begin
      keep = $urandom_range(1, msg_q.size());
      while (msg_q.size() > keep) void'(msg_q.pop_back());
    end else if (shape == 6) begin
      repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{msg_byte: b, end_of_message: eom};
    // stall only moves after a rising edge, so look at it mid-cycle
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic send_message();
    sender_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < msg_q.size(); i++) begin
      send_byte(msg_q[i], i == msg_q.size() - 1);
    end
  endtask

  task automatic send_directed();
    string many;
    // end of message on the first byte
    msg_q.delete();
    msg_q.push_back(8'hff);
    send_message();
    // every tag kind, all-ones int, zero float, empty string, short blob
    msg_q.delete();
    msg_q.push_back(8'h2f);
    msg_q.push_back(8'h80);
    msg_q.push_back(CharNul);
    add_padding();
    msg_q.push_back(CharComma);
    add_tags("ifsb");
    add_word('1);
    add_word('0);
    add_word('0);
    add_word(32'd3);
    add_word(32'hff00_8000);
    send_message();
    // missing comma
    msg_q.delete();
    add_address(2);
    msg_q.push_back(8'h2d);
    msg_q.push_back(CharI);
    send_message();
    // unsupported tag, then a cut-off int
    msg_q.delete();
    add_address(1);
    msg_q.push_back(CharComma);
    add_tags("xi");
    msg_q.push_back(8'h12);
    msg_q.push_back(8'h34);
    send_message();
    // more tags than the store holds
    msg_q.delete();
    add_address(0);
    msg_q.push_back(CharComma);
    many = "";
    repeat (34) many = {many, "i"};
    add_tags(many);
    add_word(32'h7fff_ffff);
    add_word(32'h8000_0000);
    send_message();
    // zero-length blob, then a huge blob cut short
    msg_q.delete();
    add_address(3);
    msg_q.push_back(CharComma);
    add_tags("bb");
    add_word('0);
    add_word('1);
    repeat (3) msg_q.push_back(8'($urandom));
    send_message();
    // string followed by trailing bytes
    msg_q.delete();
    add_address(4);
    msg_q.push_back(CharComma);
    add_tags("s");
    add_args("s");
    msg_q.push_back(8'h7f);
    msg_q.push_back(8'h01);
    send_message();
  endtask

  // result side: random stalls, steady stretches and two long hold-offs
  initial begin
    int hold;
    int taken;
    bit steady;
    taken     = 0;
    steady    = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      if (taken == 120 || taken == 400) hold = 80;
      else hold = steady ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      taken++;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data           = '0;
    sender_steady     = 1'b0;
    random_bytes_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    while (random_bytes_sent < RandomBytes) begin
      build_random_message();
      random_bytes_sent += msg_q.size();
      send_message();
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
